/* rtl/lph_pkg.sv */
// shared types and constants for the linear probing hash table
package lph_pkg;

  localparam int TABLE_BITS_MAX = 8;
  localparam int SLOT_COUNT     = 1 << TABLE_BITS_MAX;
  localparam int IDX_W          = TABLE_BITS_MAX;
  localparam int CNT_W          = TABLE_BITS_MAX + 1;
  localparam int TB_W           = 4;
  localparam int KEY_W          = 32;
  localparam int HASH_W         = 32;
  localparam int VALUE_W        = 32;
  localparam logic [TB_W-1:0] TABLE_BITS_RESET = TB_W'(TABLE_BITS_MAX);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } lph_op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } lph_status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } lph_state_t;

  typedef struct packed {
    lph_op_t              operation;
    logic [KEY_W-1:0]     key;
    logic [HASH_W-1:0]    hash_value;
    logic [VALUE_W-1:0]   entry_value;
  } lph_req_t;

  typedef struct packed {
    lph_status_t          status;
    logic [VALUE_W-1:0]   found_value;
    logic [CNT_W-1:0]     entries_used;
  } lph_result_t;

  // requests from the sequencer to the slot store
  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [VALUE_W-1:0]   wr_value;
  } lph_store_req_t;

  // registered read data of one slot
  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
  } lph_store_rsp_t;

endpackage

/* rtl/lph_store.sv */
// slot store: key/value memory with registered read and per-slot valid flags
module lph_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lph_pkg::lph_store_req_t req,
  output lph_pkg::lph_store_rsp_t rsp
);
  import lph_pkg::*;

  logic [KEY_W+VALUE_W-1:0] slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]    valid_r;
  logic [KEY_W+VALUE_W-1:0] rd_data_r;
  logic                     rd_valid_r;

  // key/value memory, one write and one read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_addr] <= {req.wr_key, req.wr_value};
    end
    if (req.rd_en) begin
      rd_data_r <= slot_mem[req.rd_addr];
    end
  end

  // occupancy flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.key   = rd_data_r[KEY_W+VALUE_W-1:VALUE_W];
  assign rsp.value = rd_data_r[VALUE_W-1:0];

endmodule

/* rtl/linear_probe_hash_table.sv */
// top level: open-addressing hash table with linear probing
//
// A request (insert or lookup) is taken at a rising edge with start high and
// busy low. The request carries the key, its hash and, for inserts, the value.
// The home slot is the low table_bits bits of the hash; probing walks upward
// and wraps inside the slots in use.
// One slot is probed per cycle through a memory with a registered read; a
// request probes from 1 to 2^table_bits slots before its result. An insert
// into a table whose count has reached capacity answers without probing,
// in the cycle after acceptance.
// The result appears on out_result for exactly one cycle with out_valid high.
// busy is low again in that cycle, so the next request can be taken then.
// The receiver cannot stall; every result must be taken when shown.
// The cfg channel writes table_bits (values above 8 act as 8); cfg_ready is
// always high, and writes are only meant while the block is idle.
// Reset clears all occupancy flags at once, the count, and sets table_bits to
// 8; the block takes requests right after reset.
module linear_probe_hash_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  lph_pkg::lph_req_t      in_request,
  output logic                   out_valid,
  output lph_pkg::lph_result_t   out_result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_data
);
  import lph_pkg::*;

  lph_state_t           state_r, state_nxt;
  lph_req_t             req_r, req_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     probes_r, probes_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TB_W-1:0]      table_bits_r;
  logic                 out_valid_r, out_valid_nxt;
  lph_result_t          out_r, out_nxt;

  lph_store_req_t       store_req;
  lph_store_rsp_t       store_rsp;

  logic [TB_W-1:0]      bits_use;
  logic [CNT_W-1:0]     capacity;
  logic [IDX_W-1:0]     mask;
  logic                 accept;
  logic                 full_early;
  logic                 key_hit;
  logic                 last_probe;
  logic                 finish;

  // capacity and wrap mask
  assign bits_use   = (table_bits_r > TB_W'(TABLE_BITS_MAX)) ? TB_W'(TABLE_BITS_MAX)
                                                             : table_bits_r;
  assign capacity   = CNT_W'(1) << bits_use;
  assign mask       = IDX_W'(capacity - CNT_W'(1));

  // handshake and probe outcome
  assign accept     = start && (state_r == S_IDLE);
  assign full_early = (in_request.operation == OP_INSERT) && (count_r >= capacity);
  assign key_hit    = store_rsp.valid && (store_rsp.key == req_r.key);
  assign last_probe = (probes_r == capacity - CNT_W'(1));
  assign finish     = !store_rsp.valid || key_hit || last_probe;

  lph_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (store_req),
    .rsp   (store_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !full_early) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and results
  always_comb begin
    req_nxt            = req_r;
    idx_nxt            = idx_r;
    probes_nxt         = probes_r;
    count_nxt          = count_r;
    out_valid_nxt      = 1'b0;
    out_nxt            = out_r;
    store_req          = '0;
    store_req.wr_addr  = idx_r;
    store_req.wr_key   = req_r.key;
    store_req.wr_value = req_r.entry_value;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_request;
          if (full_early) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_FULL;
            out_nxt.found_value  = '0;
            out_nxt.entries_used = count_r;
          end else begin
            idx_nxt           = in_request.hash_value[IDX_W-1:0] & mask;
            probes_nxt        = '0;
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = in_request.hash_value[IDX_W-1:0] & mask;
          end
        end
      end
      S_PROBE: begin
        if (finish) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found_value = '0;
          if (!store_rsp.valid) begin
            // empty slot ends the probe
            if (req_r.operation == OP_INSERT) begin
              store_req.wr_en = 1'b1;
              count_nxt       = count_r + CNT_W'(1);
              out_nxt.status  = ST_DONE;
            end else begin
              out_nxt.status  = ST_MISS;
            end
          end else if (key_hit) begin
            if (req_r.operation == OP_INSERT) begin
              out_nxt.status = ST_DUP;
            end else begin
              out_nxt.status      = ST_DONE;
              out_nxt.found_value = store_rsp.value;
            end
          end else begin
            // full wrap without an empty slot or a match
            out_nxt.status = (req_r.operation == OP_INSERT) ? ST_FULL : ST_MISS;
          end
          out_nxt.entries_used = count_nxt;
        end else begin
          idx_nxt           = (idx_r + IDX_W'(1)) & mask;
          probes_nxt        = probes_r + CNT_W'(1);
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = (idx_r + IDX_W'(1)) & mask;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      table_bits_r <= TABLE_BITS_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        table_bits_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    probes_r <= probes_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign cfg_ready  = 1'b1;

`ifndef SYNTHESIS
  // count moves only by one, and only with a result
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) && $past(rst_n) |->
      (count_r == $past(count_r) + CNT_W'(1)) && out_valid_r)
    else $error("occupied count changed by other than one insert");

  // a result is shown only while the sequencer is idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while probing");

  // count never exceeds the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("occupied count above slot count");

  // probing never runs past one full wrap
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (probes_r < capacity))
    else $error("probe count beyond capacity");
`endif

endmodule

/* tb/testbench.sv */
// testbench for the linear probing hash table: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module testbench;
  import lph_pkg::*;

  localparam int PHASE_ITEMS    = 222;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum bit {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  cfg_val;
    lph_req_t    req;
    bit          typed;
    lph_result_t want;
  } dir_row_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } key_rec_t;

  // clock and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  lph_req_t    in_request = '0;
  logic        out_valid;
  lph_result_t out_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // shadow copy of the table contents
  logic [TB_W-1:0]    table_bits_q = TABLE_BITS_RESET;
  logic               slot_full [SLOT_COUNT] = '{default: 1'b0};
  logic [KEY_W-1:0]   slot_key [SLOT_COUNT];
  logic [VALUE_W-1:0] slot_val [SLOT_COUNT];
  logic [CNT_W-1:0]   used_count = '0;

  lph_result_t pending_results[$];
  key_rec_t    resident_keys[$];
  dir_row_t    dir_table[$];
  logic [3:0]  phase_bits[$];
  lph_result_t oldest_result;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  linear_probe_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // probe the shadow table and apply the request to it
  function automatic lph_result_t hash_table_outcome(lph_req_t r);
    lph_result_t res;
    int unsigned bits_now, span, idx, n;
    bit          hit, has_gap;
    bits_now = (table_bits_q > TABLE_BITS_MAX) ? TABLE_BITS_MAX : table_bits_q;
    span     = 1 << bits_now;
    idx      = r.hash_value & (span - 1);
    hit      = 1'b0;
    has_gap  = 1'b0;
    for (n = 0; n < span && !hit && !has_gap; n++) begin
      if (!slot_full[idx]) has_gap = 1'b1;
      else if (slot_key[idx] == r.key) hit = 1'b1;
      else idx = (idx + 1) & (span - 1);
    end
    res.status      = ST_DONE;
    res.found_value = '0;
    if (r.operation == OP_INSERT) begin
      // full check comes before any probing
      if (used_count >= span) res.status = ST_FULL;
      else if (hit) res.status = ST_DUP;
      else if (!has_gap) res.status = ST_FULL;
      else begin
        slot_full[idx] = 1'b1;
        slot_key[idx]  = r.key;
        slot_val[idx]  = r.entry_value;
        used_count     = used_count + 1'b1;
      end
    end else if (hit) begin
      res.found_value = slot_val[idx];
    end else begin
      res.status = ST_MISS;
    end
    res.entries_used = used_count;
    return res;
  endfunction

  // present one request, hold it until taken, then record what it should return
  task automatic issue_request(input lph_req_t r, input bit typed, input lph_result_t want,
                               input bit allow_gap);
    lph_result_t predicted;
    start      <= 1'b1;
    in_request <= r;
    do @(posedge clk); while (!(start && !busy));
    predicted = hash_table_outcome(r);
    if (r.operation == OP_INSERT && predicted.status == ST_DONE)
      resident_keys.push_back('{r.key, r.hash_value});
    pending_results.push_back(typed ? want : predicted);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // table_bits is only written once every result is back
  task automatic write_table_bits(input logic [3:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    table_bits_q = v;
    cfg_valid <= 1'b0;
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h used %0d", $time,
                 out_result.status, out_result.found_value, out_result.entries_used);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_result.status !== oldest_result.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   oldest_result.status, out_result.status);
          fail_count++;
        end
        if (out_result.found_value !== oldest_result.found_value) begin
          $display("%0t: found_value expected %h got %h", $time,
                   oldest_result.found_value, out_result.found_value);
          fail_count++;
        end
        if (out_result.entries_used !== oldest_result.entries_used) begin
          $display("%0t: entries_used expected %0d got %0d", $time,
                   oldest_result.entries_used, out_result.entries_used);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    lph_req_t r;
    key_rec_t rec;
    int       pick;
    int       p, i;

    // directed rows: empty table, extremes, collisions, wrap, table size changes
    dir_table = '{
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h0, 32'h0, 32'h0}, 1'b1, '{ST_MISS, 32'h0, 9'd0}},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
        '{ST_DONE, 32'h0, 9'd1}},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h0, 32'h0, 32'h5}, 1'b1, '{ST_DUP, 32'h0, 9'd1}},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{ST_DONE, 32'hFFFF_FFFF, 9'd1}},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}, 1'b1,
        '{ST_DONE, 32'h0, 9'd2}},
      // a stored zero value is still a hit
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA}, 1'b1,
        '{ST_DONE, 32'h0, 9'd2}},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h1, 32'h100, 32'h1234_5678}, 1'b0, '0},
      // home slot at the top, probe wraps to slot 0
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h2, 32'hFF, 32'h0000_FFFF}, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h2, 32'hABCD_EFFF, 32'h0}, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h3, 32'hFF, 32'h0}, 1'b0, '0},
      // one slot in use while four entries are stored
      '{ROW_CFG, 4'd0, '0, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h7, 32'h0, 32'h1}, 1'b1, '{ST_FULL, 32'h0, 9'd4}},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h1, 32'h1, 32'h0}, 1'b0, '0},
      // oversized value saturates
      '{ROW_CFG, 4'd15, '0, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0},
      '{ROW_CFG, 4'd2, '0, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_INSERT, 32'h9, 32'h3, 32'h9}, 1'b1, '{ST_FULL, 32'h0, 9'd4}},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h9, 32'h3, 32'h0}, 1'b0, '0},
      '{ROW_REQ, 4'd0, '{OP_LOOKUP, 32'h2, 32'h2, 32'h0}, 1'b0, '0}
    };
    phase_bits = '{4'd3, 4'd4, 4'd1, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd8};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[k]) begin
      if (dir_table[k].kind == ROW_CFG) write_table_bits(dir_table[k].cfg_val);
      else issue_request(dir_table[k].req, dir_table[k].typed, dir_table[k].want, 1'b1);
    end

    // random phases, one per entry of phase_bits; table size mostly grows toward all slots
    for (p = 0; p < phase_bits.size(); p++) begin
      write_table_bits(phase_bits[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick          = $urandom_range(0, 99);
        r.entry_value = $urandom;
        if ($urandom_range(0, 9) == 0)
          r.entry_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if (pick < 40 || resident_keys.size() == 0) begin
          // fresh key, often clustered on a few home slots
          r.operation  = OP_INSERT;
          r.key        = $urandom;
          r.hash_value = $urandom;
          if ($urandom_range(0, 1)) r.hash_value[7:0] = 8'($urandom_range(0, 15));
        end else begin
          rec          = resident_keys[$urandom_range(0, resident_keys.size() - 1)];
          r.key        = rec.key;
          r.hash_value = rec.hash;
          if (pick < 55) begin
            r.operation = OP_INSERT;
          end else if (pick < 88) begin
            r.operation = OP_LOOKUP;
          end else if (pick < 95) begin
            r.operation = OP_LOOKUP;
            r.key       = $urandom;
          end else begin
            r.operation  = OP_LOOKUP;
            r.hash_value = $urandom;
          end
        end
        issue_request(r, 1'b0, '0, p != phase_bits.size() - 1);
      end
    end

    // drain and report
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/lph_pkg.sv
rtl/lph_store.sv
rtl/linear_probe_hash_table.sv
tb/testbench.sv
